/* rtl/token_table_symbol_expander_assert.svh */
// assertion macros for the token table symbol expander
// used by the controller; needs clk and rst_n in the including module
`ifndef TOKEN_TABLE_SYMBOL_EXPANDER_ASSERT_SVH
`define TOKEN_TABLE_SYMBOL_EXPANDER_ASSERT_SVH

// same-cycle implication
`define TTS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token expander check failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token expander check failed");

`endif

/* rtl/tts_pkg.sv */
// shared types and constants of the token table symbol expander
// no dependencies
package tts_pkg;

    localparam int TTS_TOKEN_MEM_DEPTH = 4096;
    localparam int TTS_MAX_TOKEN_LEN   = 32;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_STREAM = 2'd2;

    typedef struct packed {
        logic wr_byte;
        logic wr_start;
        logic open_symbol;
        logic zero_symbol;
        logic lookup;
        logic load_start;
        logic scan_step;
        logic scan_done;
        logic load_char;
        logic load_mark;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_symbol;
        logic sb_zero;
        logic data_zero;
        logic len_max;
        logic no_chars;
        logic ends;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/tts_ctrl.sv */
// controller state machine of the token table symbol expander
// depends on tts_pkg and token_table_symbol_expander_assert.svh
`include "token_table_symbol_expander_assert.svh"

module tts_ctrl
    import tts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_LOOKUP    = 3'd1;
    localparam logic [2:0] S_SCAN_RD   = 3'd2;
    localparam logic [2:0] S_SCAN_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT_RD   = 3'd4;
    localparam logic [2:0] S_EMIT_WAIT = 3'd5;
    localparam logic [2:0] S_MARK      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_BYTE:  cmd.wr_byte  = 1'b1;
                        REQ_START: cmd.wr_start = 1'b1;
                        REQ_STREAM:
                        begin
                            if (sts.in_symbol)
                            begin
                                cmd.lookup = 1'b1;
                                state_next = S_LOOKUP;
                            end
                            else if (sts.sb_zero)
                            begin
                                cmd.zero_symbol = 1'b1;
                                state_next      = S_MARK;
                            end
                            else
                            begin
                                cmd.open_symbol = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                cmd.load_start = 1'b1;
                state_next     = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.data_zero || sts.len_max)
                begin
                    cmd.scan_done = 1'b1;
                    if (!sts.no_chars)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else if (sts.ends || !sts.data_zero)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_char = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_MARK:
            begin
                if (sts.out_free)
                begin
                    cmd.load_mark = 1'b1;
                    cmd.commit    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `TTS_ASSERT_NEXT(a_emit_stall_holds, (state_reg == S_EMIT_WAIT) && !sts.out_free, state_reg == S_EMIT_WAIT)
    `TTS_ASSERT_IMPLY(a_load_needs_free, cmd.load_char || cmd.load_mark, sts.out_free)
    `TTS_ASSERT_NEXT(a_scan_continues, (state_reg == S_SCAN_CHK) && !sts.data_zero && !sts.len_max, state_reg == S_SCAN_RD)
    `TTS_ASSERT_IMPLY(a_one_action, 1'b1, $onehot0({cmd.load_char, cmd.load_mark, cmd.wr_byte, cmd.wr_start, cmd.lookup}))

endmodule

/* rtl/tts_datapath.sv */
// datapath of the token table symbol expander: token stores, scan counters,
// symbol state and output register; depends on tts_pkg
module tts_datapath
    import tts_pkg::*;
#(
    parameter int TOKEN_MEM_DEPTH = TTS_TOKEN_MEM_DEPTH,
    parameter int MAX_TOKEN_LEN   = TTS_MAX_TOKEN_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [11:0] load_addr,
    input  logic [11:0] load_value,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic        symbol_end,
    output logic        run_last,
    output logic        token_overrun,
    output logic [15:0] symbol_number
);

    localparam int AW = $clog2(TOKEN_MEM_DEPTH);
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    function automatic logic [AW-1:0] fold_addr(input logic [11:0] a);
        logic [20:0] v;
        v = {9'd0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (21'(TOKEN_MEM_DEPTH) << k))
            begin
                v = v - (21'(TOKEN_MEM_DEPTH) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(TOKEN_MEM_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [7:0]  tok_mem [TOKEN_MEM_DEPTH];
    logic [11:0] start_mem [256];
    logic [7:0]  tok_rd_reg;
    logic [11:0] start_rd_reg;

    logic [7:0]    tokens_left_reg, tokens_left_next;
    logic          in_symbol_reg, in_symbol_next;
    logic          first_skipped_reg, first_skipped_next;
    logic [15:0]   symbols_done_reg, symbols_done_next;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] ptr_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] idx_reg;
    logic          ends_reg;
    logic          over_reg;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            tok_mem[fold_addr(load_addr)] <= load_value[7:0];
        end
        tok_rd_reg <= tok_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_start)
        begin
            start_mem[load_addr[7:0]] <= load_value;
        end
        if (cmd.lookup)
        begin
            start_rd_reg <= start_mem[stream_byte];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            start_reg <= fold_addr(start_rd_reg);
            ptr_reg   <= fold_addr(start_rd_reg);
            len_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            ptr_reg <= wrap_inc(ptr_reg);
            len_reg <= len_reg + 1'b1;
        end
        else if (cmd.scan_done)
        begin
            ptr_reg  <= first_skipped_reg ? start_reg : wrap_inc(start_reg);
            idx_reg  <= first_skipped_reg ? LW'(0) : LW'(1);
            ends_reg <= (tokens_left_reg == 8'd1);
            over_reg <= (tok_rd_reg != 8'd0);
        end
        else if (cmd.zero_symbol)
        begin
            ends_reg <= 1'b1;
            over_reg <= 1'b0;
        end
        else if (cmd.load_char)
        begin
            ptr_reg <= wrap_inc(ptr_reg);
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        tokens_left_next   = tokens_left_reg;
        in_symbol_next     = in_symbol_reg;
        first_skipped_next = first_skipped_reg;
        symbols_done_next  = symbols_done_reg;
        if (cmd.open_symbol)
        begin
            tokens_left_next   = stream_byte;
            in_symbol_next     = 1'b1;
            first_skipped_next = 1'b0;
        end
        else if (cmd.commit)
        begin
            if (in_symbol_reg)
            begin
                tokens_left_next = tokens_left_reg - 8'd1;
            end
            if (len_reg != '0)
            begin
                first_skipped_next = 1'b1;
            end
            // zero-length symbol or last token of the symbol
            if (!in_symbol_reg || (tokens_left_reg == 8'd1))
            begin
                in_symbol_next    = 1'b0;
                symbols_done_next = symbols_done_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_left_reg   <= '0;
            in_symbol_reg     <= 1'b0;
            first_skipped_reg <= 1'b0;
            symbols_done_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            tokens_left_reg   <= tokens_left_next;
            in_symbol_reg     <= in_symbol_next;
            first_skipped_reg <= first_skipped_next;
            symbols_done_reg  <= symbols_done_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_char || cmd.load_mark)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            out_char      <= tok_rd_reg;
            char_valid    <= 1'b1;
            symbol_end    <= ends_reg && sts.idx_last;
            run_last      <= sts.idx_last;
            token_overrun <= over_reg;
            symbol_number <= symbols_done_reg;
        end
        else if (cmd.load_mark)
        begin
            out_char      <= 8'd0;
            char_valid    <= 1'b0;
            symbol_end    <= ends_reg;
            run_last      <= 1'b1;
            token_overrun <= over_reg;
            symbol_number <= symbols_done_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        sts.in_symbol = in_symbol_reg;
        sts.sb_zero   = (stream_byte == 8'd0);
        sts.data_zero = (tok_rd_reg == 8'd0);
        sts.len_max   = (len_reg == LW'(MAX_TOKEN_LEN));
        sts.no_chars  = (len_reg == '0) || ((len_reg == LW'(1)) && !first_skipped_reg);
        sts.ends      = (tokens_left_reg == 8'd1);
        sts.idx_last  = (({1'b0, idx_reg} + 1'b1) == {1'b0, len_reg});
        sts.out_free  = !out_valid_reg || out_ready;
    end

endmodule

/* rtl/token_table_symbol_expander.sv */
// top level of the token table symbol expander
// instantiates tts_ctrl and tts_datapath; depends on tts_pkg
//
// channel  direction  handshake            payload
// input    in         in_valid / in_ready  req_type load_addr load_value stream_byte
// output   out        out_valid/out_ready  out_char char_valid symbol_end run_last
//                                          token_overrun symbol_number
//
// load requests and a nonzero symbol count byte are handled in idle, a zero count byte
// also in the mark state; a token number byte is scanned, then emitted: one read port
// on the token store with registered data, visited once to find the end and once to emit
// token stores are not cleared at reset; symbol state resets to zero
// results wait in the output register; the next request is taken once a run is done
module token_table_symbol_expander
    import tts_pkg::*;
#(
    parameter int TOKEN_MEM_DEPTH = TTS_TOKEN_MEM_DEPTH,
    parameter int MAX_TOKEN_LEN   = TTS_MAX_TOKEN_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] load_addr,
    input  logic [11:0] load_value,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        char_valid,
    output logic        symbol_end,
    output logic        run_last,
    output logic        token_overrun,
    output logic [15:0] symbol_number
);

    cmd_t cmd;
    sts_t sts;

    tts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    tts_datapath
    #(
        .TOKEN_MEM_DEPTH (TOKEN_MEM_DEPTH),
        .MAX_TOKEN_LEN   (MAX_TOKEN_LEN)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .load_addr     (load_addr),
        .load_value    (load_value),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_char      (out_char),
        .char_valid    (char_valid),
        .symbol_end    (symbol_end),
        .run_last      (run_last),
        .token_overrun (token_overrun),
        .symbol_number (symbol_number)
    );

endmodule

/* tb/sv/tts_expand_checker.sv */
`timescale 1ns / 1ps
// request and result monitor for the token table symbol expander: predicts the characters
// every accepted request yields and compares them with the output channel; uses tts_pkg
module tts_expand_checker
    import tts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] load_addr,
    input  logic [11:0] load_value,
    input  logic [7:0]  stream_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_char,
    input  logic        char_valid,
    input  logic        symbol_end,
    input  logic        run_last,
    input  logic        token_overrun,
    input  logic [15:0] symbol_number,
    output int          mismatches,
    output int          pending,
    output int          results_seen,
    output int          symbols_seen
);

    typedef struct packed {
        logic [7:0]  ch;
        logic        valid;
        logic        sym_end;
        logic        last;
        logic        over;
        logic [15:0] num;
    } expansion_t;

    logic [7:0]  token_mem [TTS_TOKEN_MEM_DEPTH];
    logic [11:0] start_tab [256];
    logic [7:0]  tokens_left;
    logic        in_symbol;
    logic        first_dropped;
    logic [15:0] symbol_count;
    expansion_t  expected_chars [$];

    task automatic expand_request(input logic [1:0] kind, input logic [11:0] addr,
                                  input logic [11:0] value, input logic [7:0] sbyte);
        int         base;
        int         len;
        logic       over;
        logic       ends;
        logic [7:0] run [$];
        logic [15:0] num;
        case (kind)
            REQ_BYTE:  token_mem[addr % TTS_TOKEN_MEM_DEPTH] = value[7:0];
            REQ_START: start_tab[addr[7:0]] = value;
            REQ_STREAM:
            begin
                if (!in_symbol)
                begin
                    if (sbyte == 8'd0)
                    begin
                        expected_chars.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, symbol_count});
                        symbol_count = symbol_count + 16'd1;
                    end
                    else
                    begin
                        tokens_left   = sbyte;
                        in_symbol     = 1'b1;
                        first_dropped = 1'b0;
                    end
                end
                else
                begin
                    num  = symbol_count;
                    base = start_tab[sbyte] % TTS_TOKEN_MEM_DEPTH;
                    len  = 0;
                    while (len < TTS_MAX_TOKEN_LEN &&
                           token_mem[(base + len) % TTS_TOKEN_MEM_DEPTH] != 8'h00)
                        len++;
                    over = (len == TTS_MAX_TOKEN_LEN) &&
                           (token_mem[(base + len) % TTS_TOKEN_MEM_DEPTH] != 8'h00);
                    for (int i = 0; i < len; i++)
                    begin
                        if (first_dropped)
                            run.push_back(token_mem[(base + i) % TTS_TOKEN_MEM_DEPTH]);
                        else
                            first_dropped = 1'b1;
                    end
                    tokens_left = tokens_left - 8'd1;
                    ends = (tokens_left == 8'd0);
                    if (ends)
                    begin
                        in_symbol    = 1'b0;
                        symbol_count = symbol_count + 16'd1;
                    end
                    if (run.size() == 0)
                    begin
                        // silent run still shows up when it closes the symbol or was cut off
                        if (ends || over)
                            expected_chars.push_back('{8'h00, 1'b0, ends, 1'b1, over, num});
                    end
                    else
                    begin
                        foreach (run[i])
                            expected_chars.push_back('{run[i], 1'b1,
                                ends && (i == run.size() - 1), i == run.size() - 1, over, num});
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        expansion_t want;
        if (expected_chars.size() == 0)
        begin
            $error("result with nothing expected: out_char 0x%0h", out_char);
            mismatches++;
        end
        else
        begin
            want = expected_chars.pop_front();
            check_field("out_char", want.ch, out_char);
            check_field("char_valid", want.valid, char_valid);
            check_field("symbol_end", want.sym_end, symbol_end);
            check_field("run_last", want.last, run_last);
            check_field("token_overrun", want.over, token_overrun);
            check_field("symbol_number", want.num, symbol_number);
        end
        results_seen++;
        if (symbol_end === 1'b1)
            symbols_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tokens_left   = 8'd0;
            in_symbol     = 1'b0;
            first_dropped = 1'b0;
            symbol_count  = 16'd0;
            expected_chars.delete();
            mismatches    = 0;
            pending       = 0;
            results_seen  = 0;
            symbols_seen  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expand_request(req_type, load_addr, load_value, stream_byte);
            if (out_valid && out_ready)
                check_result();
            pending = expected_chars.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// top of the token table symbol expander testbench: builds token tables, sends symbol streams
// with random gaps and gives the verdict; uses tts_pkg, the block and tts_expand_checker
module tb_top
    import tts_pkg::*;
();

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [11:0] load_addr;
    logic [11:0] load_value;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        symbol_end;
    logic        run_last;
    logic        token_overrun;
    logic [15:0] symbol_number;

    int mismatches;
    int pending;
    int results_seen;
    int symbols_seen;

    bit idle_on;
    bit hold_go;
    bit held;
    int items_sent;
    int tokens_defined;
    int stall_count;
    bit known_tok [256];
    int known_list [$];

    token_table_symbol_expander uut (.*);

    tts_expand_checker expand_chk (.*);

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_request(input logic [1:0] kind, input logic [11:0] addr,
                                input logic [11:0] value, input logic [7:0] sbyte);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        load_addr   <= addr;
        load_value  <= value;
        stream_byte <= sbyte;
        do @(posedge clk); while (!in_ready);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic send_stream(input logic [7:0] sbyte);
        send_request(REQ_STREAM, 12'($urandom), 12'($urandom), sbyte);
    endtask

    // every token ends in a written zero, so reads never leave written bytes
    task automatic define_token(input int num, input logic [11:0] base, input int len);
        for (int i = 0; i < len; i++)
            send_request(REQ_BYTE, 12'(base + i),
                         {4'($urandom), 8'($urandom_range(1, 255))}, 8'($urandom));
        send_request(REQ_BYTE, 12'(base + len), {4'($urandom), 8'h00}, 8'($urandom));
        send_request(REQ_START, {4'($urandom), 8'(num)}, base, 8'($urandom));
        if (!known_tok[num])
        begin
            known_tok[num] = 1'b1;
            known_list.push_back(num);
        end
        tokens_defined++;
    endtask

    task automatic send_symbol(input int count);
        send_stream(8'(count));
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(REQ_UNUSED, 12'($urandom), 12'($urandom), 8'($urandom));
                else
                    define_token($urandom_range(0, 255), 12'($urandom), $urandom_range(0, 3));
            end
            send_stream(8'(known_list[$urandom_range(0, known_list.size() - 1)]));
        end
    endtask

    // output side: random stalls, one long hold-off while requests keep coming
    initial
    begin : sink
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 4);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("** token_table_symbol_expander: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] directed [$];
        int count;
        int len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_BYTE;
        load_addr   = 12'd0;
        load_value  = 12'd0;
        stream_byte = 8'd0;
        idle_on     = 1'b1;
        hold_go     = 1'b0;
        stall_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // token set for the directed symbols: wrap at the top of the store, a token of
        // exactly the maximum length, empty, single-character and cut-off tokens
        define_token(0, 12'hffd, 5);
        define_token(255, 12'd100, TTS_MAX_TOKEN_LEN);
        define_token(1, 12'd200, 0);
        define_token(2, 12'd300, 1);
        define_token(3, 12'd400, TTS_MAX_TOKEN_LEN + 1);
        define_token(4, 12'd500, 3);

        // zero-length symbol, silent runs, overrun, empty token closing a symbol
        directed = '{8'd0, 8'd1, 8'd2, 8'd2, 8'd2, 8'd4, 8'd2, 8'd1, 8'd3,
                     8'd3, 8'd0, 8'd255, 8'd3, 8'd2, 8'd4, 8'd1, 8'd1, 8'd3};
        foreach (directed[i])
            send_stream(directed[i]);
        send_request(REQ_UNUSED, 12'hfff, 12'hfff, 8'hff);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET / 2)
                hold_go = 1'b1;
            if (items_sent >= ITEM_TARGET * 4 / 5)
                idle_on = 1'b0;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 36)
                                                      : $urandom_range(0, 7);
                    define_token($urandom_range(0, 255), 12'($urandom), len);
                end
                2:
                    send_request(REQ_UNUSED, 12'($urandom), 12'($urandom), 8'($urandom));
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                        count = 0;
                    else if ($urandom_range(0, 7) == 0)
                        count = $urandom_range(8, 16);
                    else
                        count = $urandom_range(1, 5);
                    send_symbol(count);
                end
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests with %0d token definitions, one %0d-cycle output hold",
                 items_sent, tokens_defined, HOLD_CYCLES);
        $display("checked %0d results over %0d completed symbols", results_seen, symbols_seen);
        if (mismatches == 0 && pending == 0)
            $display("** token_table_symbol_expander: PASSED **");
        else
            $display("** token_table_symbol_expander: FAILED **");
        $finish;
    end

endmodule
